// ===== hdl/hs2d_pkg.sv =====
package hs2d_pkg;

	// default sizes
	localparam int MAX_COLS_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

	// fixed field widths
	localparam int RATE_BITS      = 28;
	localparam int ROW_BITS       = 16;
	localparam int COLCNT_BITS    = 11;
	localparam int WEIGHT_BITS    = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;

	// smallest grid and register reset values
	localparam logic [ROW_BITS-1:0]    MIN_ROWS     = 16'd3;
	localparam logic [COLCNT_BITS-1:0] MIN_COLS     = 11'd3;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd256;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1,
		REG_WEIGHT_X  = 2'd2,
		REG_WEIGHT_Y  = 2'd3
	} cfg_reg_t;

	// which results one sample causes
	typedef struct packed {
		logic has_a;	// result of the row above
		logic has_b;	// zero result of the last row
	} res_flags_t;

endpackage

// ===== hdl/hs2d_ram.sv =====
module hs2d_ram
	import hs2d_pkg::*;
#(
	parameter int WIDTH = SAMPLE_BITS_DEF,
	parameter int DEPTH = MAX_COLS_DEF,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port, read returns old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/heat_stencil_2d.sv =====
// Five-point conduction operator over a grid streamed in raster order.
// Samples come in on sample/sample_valid/sample_stall, one word per grid point,
// row by row. Results leave on rate, row_index, col_index, run_end with
// result_valid/result_stall. A sample of row r gives the result of row r-1 in
// the same column; samples of row 0 give nothing, samples of the last row give
// two words (row r-1, then the zero of the last row itself). run_end marks the
// last word a sample causes. Boundary points always give zero.
// Pipeline: stage 1, stage 2, output register. Throughput: one sample per
// cycle unless result_stall holds it, set by the single line store read per
// sample; last-row samples take two output words each and hold the input.
// The config port writes row_count, col_count, weight_x, weight_y; writing a
// count restarts the frame at row 0, column 0. Write only while idle.
// Reset sets the counts to 3, weights to 1.0 (Q8.8) and the frame position
// to zero; line store contents are not cleared, the first two rows of a frame
// fill them. When result_stall is held the pipeline fills up (three words in
// flight) and sample_stall rises in the same cycle; nothing is dropped.
module heat_stencil_2d
	import hs2d_pkg::*;
#(
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int COL_W = $clog2(MAX_COLS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [RATE_BITS-1:0]   rate,
	output logic [ROW_BITS-1:0]           row_index,
	output logic [COL_W-1:0]              col_index,
	output logic                          run_end
);

	localparam int CNT_W  = (COLCNT_BITS > COL_W + 1) ? COLCNT_BITS : COL_W + 1;
	localparam int DIFF_W = SAMPLE_BITS + 2;
	localparam int PROD_W = DIFF_W + WEIGHT_BITS + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int EXT_W  = (SUM_W > RATE_BITS) ? SUM_W : RATE_BITS + 1;
	localparam logic signed [EXT_W-1:0] SAT_HI =
		{{(EXT_W - RATE_BITS + 1){1'b0}}, {(RATE_BITS - 1){1'b1}}};
	localparam logic signed [EXT_W-1:0] SAT_LO =
		{{(EXT_W - RATE_BITS + 1){1'b1}}, {(RATE_BITS - 1){1'b0}}};
	localparam logic [ROW_BITS-1:0] LAST_ROW_RST = MIN_ROWS - 16'd1;
	localparam logic [COL_W-1:0]    LAST_COL_RST = COL_W'(MIN_COLS - 11'd1);

	// configuration
	logic [ROW_BITS-1:0]    last_row_q;
	logic [COL_W-1:0]       last_col_q;
	logic [WEIGHT_BITS-1:0] weight_x_q;
	logic [WEIGHT_BITS-1:0] weight_y_q;
	logic [ROW_BITS-1:0]    row_cfg;
	logic [ROW_BITS-1:0]    last_row_new;
	logic [CNT_W-1:0]       col_cfg;
	logic [CNT_W-1:0]       col_eff;
	logic [COL_W-1:0]       last_col_new;
	logic                   restart;

	// frame position and input side
	logic [ROW_BITS-1:0] row_pos_q;
	logic [COL_W-1:0]    col_pos_q;
	logic                accept;
	logic                last_col_hit;
	logic [COL_W-1:0]    right_addr;
	res_flags_t          flags_in;
	logic                interior_in;

	// stage 1
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [ROW_BITS-1:0]           row_s1;
	logic [COL_W-1:0]              col_s1;
	res_flags_t                    flags_s1;
	logic                          interior_s1;
	logic signed [SAMPLE_BITS-1:0] prev_mid_q;
	logic signed [SAMPLE_BITS-1:0] up_rd;
	logic signed [SAMPLE_BITS-1:0] mid_rd;
	logic signed [SAMPLE_BITS-1:0] right_rd;
	logic signed [DIFF_W-1:0]      dv;
	logic signed [DIFF_W-1:0]      dh;
	logic signed [WEIGHT_BITS:0]   wx;
	logic signed [WEIGHT_BITS:0]   wy;
	logic signed [PROD_W-1:0]      prod_x;
	logic signed [PROD_W-1:0]      prod_y;
	logic                          s1_take;
	logic                          s1_adv;

	// stage 2
	logic                     valid_s2;
	logic                     a_done_s2;
	logic signed [PROD_W-1:0] prod_x_s2;
	logic signed [PROD_W-1:0] prod_y_s2;
	logic [ROW_BITS-1:0]      row_s2;
	logic [COL_W-1:0]         col_s2;
	res_flags_t               flags_s2;
	logic                     s2_take;
	logic                     s2_release;
	logic                     emit_a;
	logic                     emit_b;
	logic                     pending;
	logic                     s2_last;
	logic signed [SUM_W-1:0]  sum;
	logic signed [EXT_W-1:0]  scaled;
	logic signed [EXT_W-1:0]  clamped;

	// output register
	logic                        out_valid_q;
	logic signed [RATE_BITS-1:0] rate_q;
	logic [ROW_BITS-1:0]         row_index_q;
	logic [COL_W-1:0]            col_index_q;
	logic                        run_end_q;
	logic                        out_free;

	// effective counts, kept as last index
	always_comb begin
		row_cfg = cfg_data[ROW_BITS-1:0];
		last_row_new = (row_cfg < MIN_ROWS) ? LAST_ROW_RST : row_cfg - 16'd1;
		col_cfg = CNT_W'(cfg_data[COLCNT_BITS-1:0]);
		if (col_cfg < CNT_W'(MIN_COLS)) begin
			col_eff = CNT_W'(MIN_COLS);
		end else if (col_cfg > CNT_W'(MAX_COLS)) begin
			col_eff = CNT_W'(MAX_COLS);
		end else begin
			col_eff = col_cfg;
		end
		last_col_new = COL_W'(col_eff - CNT_W'(1));
	end

	assign restart = cfg_write && ((cfg_reg_t'(cfg_index) == REG_ROW_COUNT) ||
		(cfg_reg_t'(cfg_index) == REG_COL_COUNT));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= LAST_ROW_RST;
			last_col_q <= LAST_COL_RST;
			weight_x_q <= WEIGHT_RESET;
			weight_y_q <= WEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT: last_row_q <= last_row_new;
				REG_COL_COUNT: last_col_q <= last_col_new;
				REG_WEIGHT_X:  weight_x_q <= cfg_data[WEIGHT_BITS-1:0];
				REG_WEIGHT_Y:  weight_y_q <= cfg_data[WEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// handshake chain, output back to input
	assign out_free     = !out_valid_q || !result_stall;
	assign s2_take      = !valid_s2 || s2_release;
	assign s1_adv       = valid_s1 && s2_take;
	assign s1_take      = !valid_s1 || s1_adv;
	assign sample_stall = !s1_take;
	assign accept       = sample_valid && s1_take;

	// position decode for the incoming word
	assign last_col_hit   = (col_pos_q == last_col_q);
	assign right_addr     = last_col_hit ? col_pos_q : col_pos_q + COL_W'(1);
	assign flags_in.has_a = (row_pos_q != '0);
	assign flags_in.has_b = (row_pos_q == last_row_q);
	assign interior_in    = (row_pos_q != '0) && (row_pos_q != ROW_BITS'(1)) &&
		(col_pos_q != '0) && !last_col_hit;

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q <= '0;
			col_pos_q <= '0;
		end else if (restart) begin
			row_pos_q <= '0;
			col_pos_q <= '0;
		end else if (accept) begin
			if (last_col_hit) begin
				col_pos_q <= '0;
				row_pos_q <= (row_pos_q == last_row_q) ? '0 : row_pos_q + 16'd1;
			end else begin
				col_pos_q <= col_pos_q + COL_W'(1);
			end
		end
	end

	// line stores: older holds row r-2, newer row r-1 (two copies for two reads)
	hs2d_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_COLS)
	) u_older (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data (mid_rd),
		.rd_en   (accept),
		.rd_addr (col_pos_q),
		.rd_data (up_rd)
	);

	hs2d_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_COLS)
	) u_newer_mid (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_pos_q),
		.wr_data (sample),
		.rd_en   (accept),
		.rd_addr (col_pos_q),
		.rd_data (mid_rd)
	);

	hs2d_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_COLS)
	) u_newer_right (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_pos_q),
		.wr_data (sample),
		.rd_en   (accept),
		.rd_addr (right_addr),
		.rd_data (right_rd)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= sample;
			row_s1      <= row_pos_q;
			col_s1      <= col_pos_q;
			flags_s1    <= flags_in;
			interior_s1 <= interior_in;
		end
		if (s1_adv) begin
			prev_mid_q <= mid_rd;
		end
	end

	// second differences and weighting
	assign dv = DIFF_W'(up_rd) - (DIFF_W'(mid_rd) <<< 1) + DIFF_W'(sample_s1);
	assign dh = DIFF_W'(prev_mid_q) - (DIFF_W'(mid_rd) <<< 1) + DIFF_W'(right_rd);
	assign wx = signed'({1'b0, weight_x_q});
	assign wy = signed'({1'b0, weight_y_q});
	assign prod_x = dv * wx;
	assign prod_y = dh * wy;

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			a_done_s2 <= 1'b0;
		end else if (s2_take) begin
			valid_s2  <= valid_s1;
			a_done_s2 <= 1'b0;
		end else if (out_free && emit_a) begin
			a_done_s2 <= 1'b1;
		end
	end

	// stage 2 payload, boundary points carry zero products
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			prod_x_s2 <= interior_s1 ? prod_x : '0;
			prod_y_s2 <= interior_s1 ? prod_y : '0;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			flags_s2  <= flags_s1;
		end
	end

	// result sequencing out of stage 2
	assign emit_a     = valid_s2 && flags_s2.has_a && !a_done_s2;
	assign emit_b     = valid_s2 && flags_s2.has_b && !emit_a;
	assign pending    = emit_a || emit_b;
	assign s2_last    = emit_b || (emit_a && !flags_s2.has_b);
	assign s2_release = valid_s2 && (!pending || (out_free && s2_last));

	// sum, floor shift and saturation
	assign sum    = SUM_W'(prod_x_s2) + SUM_W'(prod_y_s2);
	assign scaled = EXT_W'(sum) >>> FRAC_BITS;
	always_comb begin
		if (scaled > SAT_HI) begin
			clamped = SAT_HI;
		end else if (scaled < SAT_LO) begin
			clamped = SAT_LO;
		end else begin
			clamped = scaled;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pending;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && pending) begin
			rate_q      <= emit_a ? clamped[RATE_BITS-1:0] : '0;
			row_index_q <= emit_a ? row_s2 - 16'd1 : row_s2;
			col_index_q <= col_s2;
			run_end_q   <= s2_last;
		end
	end

	assign result_valid = out_valid_q;
	assign rate         = rate_q;
	assign row_index    = row_index_q;
	assign col_index    = col_index_q;
	assign run_end      = run_end_q;

endmodule

// ===== dv/tb_top.sv =====
module tb_top
	import hs2d_pkg::*;
();

	localparam int COL_W      = $clog2(MAX_COLS_DEF);
	localparam int RAND_ITEMS = 700;
	localparam longint RATE_HI = (64'sd1 <<< (RATE_BITS - 1)) - 1;
	localparam longint RATE_LO = -(64'sd1 <<< (RATE_BITS - 1));

	// one output word as the grid should produce it
	typedef struct {
		logic signed [RATE_BITS-1:0] rate;
		logic [ROW_BITS-1:0]         row;
		logic [COL_W-1:0]            col;
		logic                        last;
	} rate_word_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// stencil predictor and store of expected rate words
	class rate_scoreboard;
		logic [ROW_BITS-1:0]          row_cfg;
		logic [COLCNT_BITS-1:0]       col_cfg;
		logic [WEIGHT_BITS-1:0]       wx_cfg;
		logic [WEIGHT_BITS-1:0]       wy_cfg;
		logic signed [SAMPLE_BITS_DEF-1:0] line_two_up [MAX_COLS_DEF];
		logic signed [SAMPLE_BITS_DEF-1:0] line_one_up [MAX_COLS_DEF];
		int unsigned cur_row;
		int unsigned cur_col;
		rate_word_t  pending_rates [$];
		int          errors;

		function new();
			row_cfg = MIN_ROWS;
			col_cfg = MIN_COLS;
			wx_cfg  = WEIGHT_RESET;
			wy_cfg  = WEIGHT_RESET;
			cur_row = 0;
			cur_col = 0;
			errors  = 0;
			foreach (line_two_up[k]) begin
				line_two_up[k] = '0;
				line_one_up[k] = '0;
			end
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// register write; a count write restarts the frame
		function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				REG_ROW_COUNT: begin
					row_cfg = value[ROW_BITS-1:0];
					cur_row = 0;
					cur_col = 0;
				end
				REG_COL_COUNT: begin
					col_cfg = value[COLCNT_BITS-1:0];
					cur_row = 0;
					cur_col = 0;
				end
				REG_WEIGHT_X: wx_cfg = value[WEIGHT_BITS-1:0];
				REG_WEIGHT_Y: wy_cfg = value[WEIGHT_BITS-1:0];
				default: ;
			endcase
		endfunction

		// words caused by one accepted sample
		function void predict_rates(logic signed [SAMPLE_BITS_DEF-1:0] s);
			int unsigned rows, cols, i, j;
			longint up, mid, left, right, dv, dh, acc, wx, wy;
			logic last_row;
			rate_word_t w;
			rows = (row_cfg < MIN_ROWS) ? MIN_ROWS : row_cfg;
			cols = (col_cfg < MIN_COLS) ? MIN_COLS : col_cfg;
			if (cols > MAX_COLS_DEF)
				cols = MAX_COLS_DEF;
			i = (cur_row >= rows) ? 0 : cur_row;
			j = (cur_col >= cols) ? 0 : cur_col;
			last_row = (i == rows - 1);
			wx = wx_cfg;
			wy = wy_cfg;

			// row above is complete now
			if (i >= 1) begin
				acc = 0;
				if (i - 1 != 0 && j != 0 && j != cols - 1) begin
					up    = line_two_up[j];
					mid   = line_one_up[j];
					left  = line_two_up[j-1];
					right = line_one_up[j+1];
					dv    = up - 2 * mid + longint'(s);
					dh    = left - 2 * mid + right;
					acc   = (dv * wx + dh * wy) >>> FRAC_BITS_DEF;
					if (acc > RATE_HI)
						acc = RATE_HI;
					if (acc < RATE_LO)
						acc = RATE_LO;
				end
				w.rate = acc[RATE_BITS-1:0];
				w.row  = ROW_BITS'(i - 1);
				w.col  = COL_W'(j);
				w.last = !last_row;
				pending_rates.push_back(w);
			end

			// last row is all boundary
			if (last_row) begin
				w.rate = '0;
				w.row  = ROW_BITS'(i);
				w.col  = COL_W'(j);
				w.last = 1'b1;
				pending_rates.push_back(w);
			end

			line_two_up[j] = line_one_up[j];
			line_one_up[j] = s;
			j++;
			if (j >= cols) begin
				j = 0;
				i++;
				if (i >= rows)
					i = 0;
			end
			cur_row = i;
			cur_col = j;
		endfunction

		task check_result(logic signed [RATE_BITS-1:0] rate, logic [ROW_BITS-1:0] row,
				logic [COL_W-1:0] col, logic last);
			rate_word_t w;
			if (pending_rates.size() == 0) begin
				report_mismatch($sformatf("unexpected word rate=%0d row=%0d col=%0d",
					rate, row, col));
				return;
			end
			w = pending_rates.pop_front();
			if (rate !== w.rate)
				report_mismatch($sformatf("rate %0d, want %0d at row %0d col %0d",
					rate, w.rate, w.row, w.col));
			if (row !== w.row)
				report_mismatch($sformatf("row_index %0d, want %0d", row, w.row));
			if (col !== w.col)
				report_mismatch($sformatf("col_index %0d, want %0d", col, w.col));
			if (last !== w.last)
				report_mismatch($sformatf("run_end %b, want %b at row %0d col %0d",
					last, w.last, w.row, w.col));
		endtask

		task check_leftover();
			if (pending_rates.size() != 0)
				report_mismatch($sformatf("%0d words never arrived", pending_rates.size()));
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_write;
	logic [CFG_INDEX_BITS-1:0]         cfg_index;
	logic [CFG_DATA_BITS-1:0]          cfg_data;
	logic                              sample_valid;
	logic                              sample_stall;
	logic signed [SAMPLE_BITS_DEF-1:0] sample;
	logic                              result_valid;
	logic                              result_stall;
	logic signed [RATE_BITS-1:0]       rate;
	logic [ROW_BITS-1:0]               row_index;
	logic [COL_W-1:0]                  col_index;
	logic                              run_end;

	rate_scoreboard sb;
	int             send_gap_pct;
	int             stall_pct;

	heat_stencil_2d i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.rate         (rate),
		.row_index    (row_index),
		.col_index    (col_index),
		.run_end      (run_end)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL heat_stencil_2d");
		$finish;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// result word monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(rate, row_index, col_index, run_end);
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_gap_pct = 80; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 80; end
			IDLE_BOTH:     begin send_gap_pct = 14; stall_pct = 14; end
			default:       begin send_gap_pct = 0;  stall_pct = 0;  end
		endcase
	endtask

	// one register write; caller closes the batch with end_writes
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.apply_reg(idx, value);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// one sample word, with optional idle cycles ahead of it
	task automatic send_sample(logic signed [SAMPLE_BITS_DEF-1:0] s);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do
			@(posedge clk);
		while (sample_stall);
		sb.predict_rates(s);
	endtask

	task automatic stop_samples();
		@(negedge clk);
		sample_valid <= 1'b0;
	endtask

	// wait out expected words, then the pipeline depth
	task automatic wait_drained();
		while (sb.pending_rates.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS_DEF-1:0] checker_sample(int r, int c, bit flip);
		bit odd;
		odd = ((r + c) % 2 == 1) ^ flip;
		return odd ? 16'sh7FFF : 16'sh8000;
	endfunction

	function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2:       return SAMPLE_BITS_DEF'($urandom_range(0, 64) - 32);
			default: return SAMPLE_BITS_DEF'($urandom);
		endcase
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return WEIGHT_RESET;
			default: return WEIGHT_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int sent;
		int phase;
		int n;
		int sel;
		sb = new();
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_ROW_COUNT;
		cfg_data     = '0;
		sample_valid = 1'b0;
		sample       = '0;
		set_idling(IDLE_NONE);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes and weights, checkerboard of extremes
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_sample(checker_sample(r, c, 1'b0));
		stop_samples();
		wait_drained();

		// counts below the minimum, full-scale weights, inverted board
		write_reg(REG_ROW_COUNT, 16'd1);
		write_reg(REG_COL_COUNT, 16'd0);
		write_reg(REG_WEIGHT_X, 16'hFFFF);
		write_reg(REG_WEIGHT_Y, 16'hFFFF);
		end_writes();
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_sample(checker_sample(r, c, 1'b1));
		stop_samples();
		wait_drained();

		// random phases over sizes, weights and idling
		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			set_idling(idle_mode_t'(phase % 4));
			sel = $urandom_range(0, 9);
			if (sel >= 3) begin
				case (sel)
					3:       write_reg(REG_ROW_COUNT, 16'hFFFF);
					4:       write_reg(REG_ROW_COUNT, CFG_DATA_BITS'($urandom_range(0, 2)));
					default: write_reg(REG_ROW_COUNT, CFG_DATA_BITS'($urandom_range(3, 7)));
				endcase
				case (sel)
					5:       write_reg(REG_COL_COUNT, CFG_DATA_BITS'($urandom_range(0, 2)));
					6:       write_reg(REG_COL_COUNT, CFG_DATA_BITS'($urandom_range(13, 40)));
					default: write_reg(REG_COL_COUNT, CFG_DATA_BITS'($urandom_range(3, 12)));
				endcase
			end
			write_reg(REG_WEIGHT_X, pick_weight());
			write_reg(REG_WEIGHT_Y, pick_weight());
			end_writes();
			n = $urandom_range(10, 60);
			repeat (n) send_sample(pick_sample());
			stop_samples();
			sent += n;
			phase++;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		sb.check_leftover();
		if (sb.errors == 0)
			$display("PASS heat_stencil_2d");
		else
			$display("FAIL heat_stencil_2d");
		$finish;
	end

endmodule
